// ===== sv/stl_pkg.sv =====
// shared types, codes and keyword tables for the source text lexer
`timescale 1ns / 1ps

package stl_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int NUM_KEYWORDS = 9;

    // token classes
    localparam logic [2:0] CLS_COMMENT    = 3'd0;
    localparam logic [2:0] CLS_WORD_CHAR  = 3'd1;
    localparam logic [2:0] CLS_KEYWORD    = 3'd2;
    localparam logic [2:0] CLS_IDENTIFIER = 3'd3;
    localparam logic [2:0] CLS_NUMBER     = 3'd4;
    localparam logic [2:0] CLS_OPERATOR   = 3'd5;
    localparam logic [2:0] CLS_SYMBOL     = 3'd6;
    localparam logic [2:0] CLS_SUMMARY    = 3'd7;

    // request kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [2:0] token_class;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [3:0] keyword_index;
        logic       last;
    } token_t;

    // keyword text, first character in the low byte, zero padded
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
        logic [63:0] text;
        unique case (k)
            4'd0:    text = 64'h0000_0000_0074_6e69; // int
            4'd1:    text = 64'h0000_0000_0000_6669; // if
            4'd2:    text = 64'h0000_0000_6e65_6874; // then
            4'd3:    text = 64'h0000_0000_6573_6c65; // else
            4'd4:    text = 64'h0000_0066_6964_6e65; // endif
            4'd5:    text = 64'h0000_0065_6c69_6877; // while
            4'd6:    text = 64'h0000_0000_0000_6f64; // do
            4'd7:    text = 64'h0000_006f_6464_6e65; // enddo
            4'd8:    text = 64'h0000_0074_6e69_7270; // print
            default: text = 64'h0;
        endcase
        return text[{pos, 3'b000} +: 8];
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] k);
        logic [2:0] len;
        unique case (k)
            4'd0:    len = 3'd3;
            4'd1:    len = 3'd2;
            4'd2:    len = 3'd4;
            4'd3:    len = 3'd4;
            4'd4:    len = 3'd5;
            4'd5:    len = 3'd5;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd5;
            4'd8:    len = 3'd5;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/source_text_lexer_unit.sv =====
// top level of the source text lexer: input register, scanner and result bank
`timescale 1ns / 1ps

// usage
//   byte channel: byte_valid / byte_stall carry one request, either a source
//   byte (kind 0, text_byte) or an end-of-input marker (kind 1)
//   token channel: token_valid / token_stall carry one token per transfer;
//   a request yields zero to two tokens, the final one has last set
// flow and throughput
//   a request is held in the input register until the result bank is free,
//   is then scanned in a single pass and registered into the result bank,
//   where its first token shows
//   one request per cycle while each request yields at most one token and
//   token_stall stays low; a request with several tokens holds the token port
//   until all are taken, and one yielding none still passes the input register
// reset
//   rst_n clears the input valid flag, the token count and the scanner state
//   (normal mode, empty word, zero line count)
// backpressure
//   while token_stall is high the shown token holds; one more request is
//   still taken into the input register, then byte_stall rises
// end of input flushes any pending token, reports the line total in the
// summary token and returns the scanner to its reset state

module source_text_lexer_unit
    import stl_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32,
    parameter int LINE_COUNT_WIDTH = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // byte channel
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  logic                        kind,
    input  logic [7:0]                  text_byte,
    // token channel
    output logic                        token_valid,
    input  logic                        token_stall,
    output logic [2:0]                  token_class,
    output logic [7:0]                  first_char,
    output logic [7:0]                  second_char,
    output logic [NUMBER_WIDTH-1:0]     number_value,
    output logic [3:0]                  keyword_index,
    output logic [LINE_COUNT_WIDTH-1:0] line_total,
    output logic                        last
);

    // input register
    logic       in_valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;

    logic       accept;
    logic       fire;
    logic       take;
    logic       q_free;

    token_t                      scan_toks [MAX_RESULTS];
    logic [1:0]                  scan_count;
    logic [NUMBER_WIDTH-1:0]     scan_number;
    logic [LINE_COUNT_WIDTH-1:0] scan_lines;
    token_t                      head;

    // scan the held request once the result bank empties this cycle
    assign fire       = in_valid_reg && q_free;
    assign byte_stall = in_valid_reg && !fire;
    assign accept     = byte_valid && !byte_stall;
    assign take       = token_valid && !token_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            byte_reg <= text_byte;
        end
    end

    stl_scan #(
        .NUMBER_WIDTH     (NUMBER_WIDTH),
        .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .kind       (kind_reg),
        .text_byte  (byte_reg),
        .toks       (scan_toks),
        .tok_count  (scan_count),
        .number_out (scan_number),
        .lines_out  (scan_lines)
    );

    stl_result_q #(
        .NUMBER_WIDTH     (NUMBER_WIDTH),
        .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
    ) u_result_q (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .load_count  (scan_count),
        .load_toks   (scan_toks),
        .load_number (scan_number),
        .load_lines  (scan_lines),
        .take        (take),
        .head        (head),
        .head_number (number_value),
        .head_lines  (line_total),
        .valid       (token_valid),
        .free        (q_free)
    );

    // token fields straight from the head of the result bank
    assign token_class   = head.token_class;
    assign first_char    = head.first_char;
    assign second_char   = head.second_char;
    assign keyword_index = head.keyword_index;
    assign last          = head.last;

endmodule

// ===== sv/stl_scan.sv =====
// scanner state and single-pass token classification for one request
`timescale 1ns / 1ps

module stl_scan
    import stl_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32,
    parameter int LINE_COUNT_WIDTH = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic                        kind,
    input  logic [7:0]                  text_byte,
    output token_t                      toks [MAX_RESULTS],
    output logic [1:0]                  tok_count,
    output logic [NUMBER_WIDTH-1:0]     number_out,
    output logic [LINE_COUNT_WIDTH-1:0] lines_out
);

    localparam logic [2:0] M_NORMAL  = 3'd0;
    localparam logic [2:0] M_SLASH   = 3'd1;
    localparam logic [2:0] M_COMMENT = 3'd2;
    localparam logic [2:0] M_STAR    = 3'd3;
    localparam logic [2:0] M_NUMBER  = 3'd4;
    localparam logic [2:0] M_WORD    = 3'd5;
    localparam logic [2:0] M_OPER    = 3'd6;

    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [NUM_KEYWORDS-1:0] ALL_CAND = '1;

    logic [2:0]                  mode_reg, mode_next;
    logic [7:0]                  pend_reg, pend_next;
    logic [NUMBER_WIDTH-1:0]     acc_reg, acc_next;
    logic [NUM_KEYWORDS-1:0]     cand_reg, cand_next;
    logic [2:0]                  wlen_reg, wlen_next;
    logic [LINE_COUNT_WIDTH-1:0] lines_reg, lines_next;

    logic                        is_digit, is_alpha, is_oper;
    logic [NUMBER_WIDTH+3:0]     acc_x10;

    assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign is_alpha = ((text_byte >= 8'h61) && (text_byte <= 8'h7a)) ||
                      ((text_byte >= 8'h41) && (text_byte <= 8'h5a));
    assign is_oper  = (text_byte == 8'h2b) || (text_byte == 8'h2d) ||
                      (text_byte == CH_STAR) || (text_byte == CH_SLASH) ||
                      (text_byte == 8'h3d) || (text_byte == 8'h3e) ||
                      (text_byte == 8'h3c) || (text_byte == 8'h21);

    // acc * 10 + digit as two shifted adds, top bits flag overflow
    assign acc_x10 = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                   + {{NUMBER_WIDTH{1'b0}}, text_byte[3:0]};

    always_comb
    begin
        logic [1:0] n;
        logic       rescan;
        logic       hit;
        logic [3:0] found;

        mode_next  = mode_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        cand_next  = cand_reg;
        wlen_next  = wlen_reg;
        lines_next = lines_reg;
        n          = 2'd0;
        rescan     = 1'b0;
        hit        = 1'b0;
        found      = 4'd0;
        number_out = '0;
        lines_out  = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            toks[i] = '0;
        end

        if (kind == KIND_END)
        begin
            unique case (mode_reg)
                M_SLASH:
                begin
                    toks[n] = '{CLS_OPERATOR, CH_SLASH, 8'h00, 4'd0, 1'b0};
                    n = n + 2'd1;
                end
                M_OPER:
                begin
                    toks[n] = '{CLS_OPERATOR, pend_reg, 8'h00, 4'd0, 1'b0};
                    n = n + 2'd1;
                end
                M_NUMBER:
                begin
                    toks[n] = '{CLS_NUMBER, 8'h00, 8'h00, 4'd0, 1'b0};
                    n = n + 2'd1;
                    number_out = acc_reg;
                end
                M_WORD:
                begin
                    for (int k = NUM_KEYWORDS - 1; k >= 0; k--)
                    begin
                        if (cand_reg[k] && (kw_len(4'(k)) == wlen_reg))
                        begin
                            hit   = 1'b1;
                            found = 4'(k);
                        end
                    end
                    toks[n] = hit ? '{CLS_KEYWORD, 8'h00, 8'h00, found, 1'b0}
                                  : '{CLS_IDENTIFIER, 8'h00, 8'h00, 4'd0, 1'b0};
                    n = n + 2'd1;
                end
                M_STAR:
                begin
                    toks[n] = '{CLS_COMMENT, CH_STAR, 8'h00, 4'd0, 1'b0};
                    n = n + 2'd1;
                    if (lines_reg != '1)
                        lines_next = lines_reg + 1'b1;
                end
                M_COMMENT:
                begin
                    if (lines_reg != '1)
                        lines_next = lines_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
            toks[n] = '{CLS_SUMMARY, 8'h00, 8'h00, 4'd0, 1'b0};
            n = n + 2'd1;
            lines_out  = lines_next;
            mode_next  = M_NORMAL;
            pend_next  = 8'h00;
            acc_next   = '0;
            cand_next  = ALL_CAND;
            wlen_next  = 3'd0;
            lines_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                M_SLASH, M_OPER:
                begin
                    if (mode_reg == M_SLASH && text_byte == CH_STAR)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        pend_next = 8'h00;
                        if (is_oper)
                        begin
                            toks[n] = '{CLS_OPERATOR,
                                        (mode_reg == M_SLASH) ? CH_SLASH : pend_reg,
                                        text_byte, 4'd0, 1'b0};
                            n = n + 2'd1;
                            mode_next = M_NORMAL;
                        end
                        else
                        begin
                            toks[n] = '{CLS_OPERATOR,
                                        (mode_reg == M_SLASH) ? CH_SLASH : pend_reg,
                                        8'h00, 4'd0, 1'b0};
                            n = n + 2'd1;
                            rescan = 1'b1;
                        end
                    end
                end
                M_COMMENT:
                begin
                    if (text_byte == CH_STAR)
                    begin
                        mode_next = M_STAR;
                    end
                    else
                    begin
                        toks[n] = '{CLS_COMMENT, text_byte, 8'h00, 4'd0, 1'b0};
                        n = n + 2'd1;
                    end
                end
                M_STAR:
                begin
                    if (text_byte == CH_SLASH)
                    begin
                        if (lines_reg != '1)
                            lines_next = lines_reg + 1'b1;
                        mode_next = M_NORMAL;
                    end
                    else
                    begin
                        toks[n] = '{CLS_COMMENT, CH_STAR, 8'h00, 4'd0, 1'b0};
                        n = n + 2'd1;
                        if (text_byte != CH_STAR)
                        begin
                            toks[n] = '{CLS_COMMENT, text_byte, 8'h00, 4'd0, 1'b0};
                            n = n + 2'd1;
                            mode_next = M_COMMENT;
                        end
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit)
                    begin
                        if (acc_x10[NUMBER_WIDTH+3:NUMBER_WIDTH] != 4'd0)
                            acc_next = '1;
                        else
                            acc_next = acc_x10[NUMBER_WIDTH-1:0];
                    end
                    else
                    begin
                        toks[n] = '{CLS_NUMBER, 8'h00, 8'h00, 4'd0, 1'b0};
                        n = n + 2'd1;
                        number_out = acc_reg;
                        acc_next = '0;
                        rescan = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (is_alpha || is_digit)
                    begin
                        for (int k = 0; k < NUM_KEYWORDS; k++)
                        begin
                            if (kw_char(4'(k), wlen_reg) != text_byte)
                                cand_next[k] = 1'b0;
                        end
                        if (wlen_reg != 3'd7)
                            wlen_next = wlen_reg + 3'd1;
                        toks[n] = '{CLS_WORD_CHAR, text_byte, 8'h00, 4'd0, 1'b0};
                        n = n + 2'd1;
                    end
                    else
                    begin
                        for (int k = NUM_KEYWORDS - 1; k >= 0; k--)
                        begin
                            if (cand_reg[k] && (kw_len(4'(k)) == wlen_reg))
                            begin
                                hit   = 1'b1;
                                found = 4'(k);
                            end
                        end
                        toks[n] = hit ? '{CLS_KEYWORD, 8'h00, 8'h00, found, 1'b0}
                                      : '{CLS_IDENTIFIER, 8'h00, 8'h00, 4'd0, 1'b0};
                        n = n + 2'd1;
                        cand_next = ALL_CAND;
                        wlen_next = 3'd0;
                        rescan = 1'b1;
                    end
                end
                default:
                begin
                    rescan = 1'b1;
                end
            endcase

            // scan the byte from normal context
            if (rescan)
            begin
                mode_next = M_NORMAL;
                if (text_byte == CH_SLASH)
                begin
                    mode_next = M_SLASH;
                end
                else if (is_digit)
                begin
                    acc_next  = {{(NUMBER_WIDTH-4){1'b0}}, text_byte[3:0]};
                    mode_next = M_NUMBER;
                end
                else if (is_alpha)
                begin
                    for (int k = 0; k < NUM_KEYWORDS; k++)
                    begin
                        cand_next[k] = (kw_char(4'(k), 3'd0) == text_byte);
                    end
                    wlen_next = 3'd1;
                    toks[n] = '{CLS_WORD_CHAR, text_byte, 8'h00, 4'd0, 1'b0};
                    n = n + 2'd1;
                    mode_next = M_WORD;
                end
                else if (text_byte == CH_SPACE || text_byte == CH_TAB)
                begin
                end
                else if (text_byte == CH_NL)
                begin
                    if (lines_next != '1)
                        lines_next = lines_next + 1'b1;
                end
                else if (is_oper)
                begin
                    pend_next = text_byte;
                    mode_next = M_OPER;
                end
                else
                begin
                    toks[n] = '{CLS_SYMBOL, text_byte, 8'h00, 4'd0, 1'b0};
                    n = n + 2'd1;
                end
            end
        end

        // flag the final token of this request
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            toks[i].last = ((2'(i) + 2'd1) == n);
        end
        tok_count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_NORMAL;
            pend_reg  <= 8'h00;
            acc_reg   <= '0;
            cand_reg  <= ALL_CAND;
            wlen_reg  <= 3'd0;
            lines_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            acc_reg   <= acc_next;
            cand_reg  <= cand_next;
            wlen_reg  <= wlen_next;
            lines_reg <= lines_next;
        end
    end

endmodule

// ===== sv/stl_result_q.sv =====
// result register bank holding the tokens of one request until taken
`timescale 1ns / 1ps

module stl_result_q
    import stl_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32,
    parameter int LINE_COUNT_WIDTH = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [1:0]                  load_count,
    input  token_t                      load_toks [MAX_RESULTS],
    input  logic [NUMBER_WIDTH-1:0]     load_number,
    input  logic [LINE_COUNT_WIDTH-1:0] load_lines,
    input  logic                        take,
    output token_t                      head,
    output logic [NUMBER_WIDTH-1:0]     head_number,
    output logic [LINE_COUNT_WIDTH-1:0] head_lines,
    output logic                        valid,
    output logic                        free
);

    token_t                      entry_reg [MAX_RESULTS];
    token_t                      entry_next [MAX_RESULTS];
    logic [1:0]                  rem_reg, rem_next;
    logic [NUMBER_WIDTH-1:0]     number_reg;
    logic [LINE_COUNT_WIDTH-1:0] lines_reg;

    assign valid = (rem_reg != 2'd0);
    assign free  = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && take);
    assign head  = entry_reg[0];
    assign head_number = (entry_reg[0].token_class == CLS_NUMBER) ? number_reg : '0;
    assign head_lines  = (entry_reg[0].token_class == CLS_SUMMARY) ? lines_reg : '0;

    always_comb
    begin
        entry_next = entry_reg;
        rem_next   = rem_reg;
        if (load)
        begin
            entry_next = load_toks;
            rem_next   = load_count;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                entry_next[i] = entry_reg[i+1];
            end
            rem_next = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (load)
        begin
            number_reg <= load_number;
            lines_reg  <= load_lines;
        end
    end

endmodule
